/* src/lmfs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfs_pkg
// Shared widths, request codes and byte helpers for the LED matrix scroller.
// ----------------------------------------------------------------------------
package lmfs_pkg;

    localparam int NUM_COLUMNS_DEF = 32;
    localparam int DATA_W          = 8;
    localparam int ROWS            = 8;
    localparam int SEG_COLS        = 8;
    localparam int NUM_SEGS        = 4;
    localparam int DISP_COLS       = SEG_COLS * NUM_SEGS;
    localparam int TYPE_W          = 3;
    localparam int COL_W           = 5;
    localparam int ROW_W           = 3;
    localparam int ADDR_W          = 4;

    typedef enum logic [TYPE_W-1:0] {
        REQ_CLEAR      = 3'd0,
        REQ_SET        = 3'd1,
        REQ_ROLL_LEFT  = 3'd2,
        REQ_ROLL_RIGHT = 3'd3,
        REQ_ROLL_DOWN  = 3'd4,
        REQ_REFRESH    = 3'd5
    } req_t;

    // rotate a byte towards its MSB
    function automatic logic [DATA_W-1:0] rotl8(input logic [DATA_W-1:0] b,
                                                input logic [ROW_W-1:0] amt);
        logic [2*DATA_W-1:0] d;
        d = {b, b} << amt;
        return d[2*DATA_W-1:DATA_W];
    endfunction

    function automatic logic [DATA_W-1:0] bitrev8(input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] r;
        for (int i = 0; i < DATA_W; i++)
        begin
            r[i] = b[DATA_W-1-i];
        end
        return r;
    endfunction

endpackage

/* src/lmfs_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfs_if
// Valid/ready channels: request items in, display register writes out.
// ----------------------------------------------------------------------------
interface lmfs_req_if;
    logic                        valid;
    logic                        ready;
    logic [lmfs_pkg::TYPE_W-1:0] req_type;
    logic [lmfs_pkg::COL_W-1:0]  column;
    logic [lmfs_pkg::ROW_W-1:0]  row;

    modport source (output valid, output req_type, output column, output row,
                    input ready);
    modport sink   (input valid, input req_type, input column, input row,
                    output ready);
endinterface

interface lmfs_wr_if;
    logic                        valid;
    logic                        ready;
    logic [lmfs_pkg::ADDR_W-1:0] reg_address;
    logic [lmfs_pkg::DATA_W-1:0] reg_data;
    logic                        frame_end;
    logic                        last;

    modport source (output valid, output reg_address, output reg_data,
                    output frame_end, output last, input ready);
    modport sink   (input valid, input reg_address, input reg_data,
                    input frame_end, input last, output ready);
endinterface

/* src/lmfs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfs_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lmfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/led_matrix_frame_scroller_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_frame_scroller_core
// Column frame buffer for four chained 8x8 LED segments.
// ----------------------------------------------------------------------------
// Usage:
//   req : request items (clear, set pixel, roll left/right/down, refresh).
//         ready is high only while the block is between requests.
//   wr  : display register writes produced by a refresh, 32 per refresh,
//         row-major, four segments per row, frame_end on the fourth of each
//         row and last on the final one.
// Operation:
//   clear and the three rolls complete when accepted; set pixel reads, then
//   writes back to the column RAM.
//   refresh reads the 32 displayed columns, one per cycle through the single
//   RAM read port, into a row snapshot (ST_SNAP, then ST_TAIL), then emits
//   the writes in ST_EMIT; a stalled wr holds up the emission, and the block
//   is ready again once the last write is loaded for wr.
//   Rolls only move a column offset and a bit rotation, so they do not touch
//   the RAM. Clear drops the per-column valid bits.
// Reset: the store reads as all zeros at once; no clearing pass is needed.
// A stalled wr holds its item while the next request can already be taken.
// ----------------------------------------------------------------------------
module led_matrix_frame_scroller_core #(
    parameter int NUM_COLUMNS = lmfs_pkg::NUM_COLUMNS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lmfs_req_if.sink   req,
    lmfs_wr_if.source  wr
);

    localparam int AW     = $clog2(NUM_COLUMNS);
    localparam int IW     = (AW + 1 > lmfs_pkg::COL_W + 1) ? AW + 1 : lmfs_pkg::COL_W + 1;
    localparam int RD_W   = $clog2(lmfs_pkg::DISP_COLS);
    localparam int NUM_WR = lmfs_pkg::ROWS * lmfs_pkg::NUM_SEGS;
    localparam int CNT_W  = $clog2(NUM_WR);
    localparam int DW     = lmfs_pkg::DATA_W;
    localparam int SEG_W  = $clog2(lmfs_pkg::NUM_SEGS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SP_WRITE,
        ST_SNAP,
        ST_TAIL,
        ST_EMIT
    } state_t;

    state_t                         state_reg;
    logic [NUM_COLUMNS-1:0]         valid_reg;
    logic [AW-1:0]                  off_reg;
    logic [lmfs_pkg::ROW_W-1:0]     rot_reg;
    logic [RD_W-1:0]                rd_cnt_reg;
    logic [CNT_W-1:0]               out_cnt_reg;
    logic                           out_valid_reg;
    logic                           cap_valid_reg;

    logic [AW-1:0]                  sp_addr_reg;
    logic [DW-1:0]                  sp_mask_reg;
    logic [AW-1:0]                  pend_addr_reg;
    logic [RD_W-1:0]                pend_idx_reg;
    logic                           pend_in_reg;
    logic [lmfs_pkg::DISP_COLS-1:0] rows_reg [lmfs_pkg::ROWS];
    logic [lmfs_pkg::ADDR_W-1:0]    out_addr_reg;
    logic [DW-1:0]                  out_data_reg;
    logic                           out_fe_reg;
    logic                           out_last_reg;

    logic                           req_fire;
    logic [IW-1:0]                  lidx_ext;
    logic [IW-1:0]                  sum_ext;
    logic [IW-1:0]                  phys_ext;
    logic                           in_range;
    logic [AW-1:0]                  phys;
    logic                           ram_re;
    logic                           ram_we;
    logic [DW-1:0]                  ram_wdata;
    logic [DW-1:0]                  ram_rdata;
    logic [DW-1:0]                  cap_byte;
    logic                           out_load;
    logic [lmfs_pkg::ROW_W-1:0]     emit_row;
    logic [SEG_W-1:0]               emit_seg;
    logic [lmfs_pkg::DISP_COLS-1:0] emit_word;
    logic [IW-1:0]                  off_inc;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    // logical column -> RAM entry, through the roll offset
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            lidx_ext = IW'(req.column);
        end
        else
        begin
            lidx_ext = IW'(rd_cnt_reg);
        end
        sum_ext  = lidx_ext + IW'(off_reg);
        in_range = (lidx_ext < IW'(NUM_COLUMNS));
        if (sum_ext >= IW'(NUM_COLUMNS))
        begin
            phys_ext = sum_ext - IW'(NUM_COLUMNS);
        end
        else
        begin
            phys_ext = sum_ext;
        end
        phys = phys_ext[AW-1:0];
    end

    assign off_inc = IW'(off_reg) + IW'(1);

    assign ram_re = (req_fire && (req.req_type == lmfs_pkg::REQ_SET) && in_range)
                    || (state_reg == ST_SNAP);
    assign ram_we = (state_reg == ST_SP_WRITE);
    assign ram_wdata = (valid_reg[sp_addr_reg] ? ram_rdata : '0) | sp_mask_reg;

    // unwritten entries read as zero; stored bytes carry the row rotation
    assign cap_byte = (pend_in_reg && valid_reg[pend_addr_reg])
                      ? lmfs_pkg::rotl8(ram_rdata, rot_reg) : '0;

    assign emit_row  = out_cnt_reg[CNT_W-1:SEG_W];
    assign emit_seg  = out_cnt_reg[SEG_W-1:0];
    assign emit_word = rows_reg[emit_row];
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || wr.ready);

    lmfs_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_COLUMNS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sp_addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (phys),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            off_reg       <= '0;
            rot_reg       <= '0;
            rd_cnt_reg    <= '0;
            out_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            cap_valid_reg <= 1'b0;
        end
        else
        begin
            cap_valid_reg <= (state_reg == ST_SNAP);
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (wr.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        case (req.req_type)
                            lmfs_pkg::REQ_CLEAR:
                            begin
                                valid_reg <= '0;
                            end
                            lmfs_pkg::REQ_SET:
                            begin
                                if (in_range)
                                begin
                                    state_reg <= ST_SP_WRITE;
                                end
                            end
                            lmfs_pkg::REQ_ROLL_LEFT:
                            begin
                                if (off_inc >= IW'(NUM_COLUMNS))
                                begin
                                    off_reg <= '0;
                                end
                                else
                                begin
                                    off_reg <= off_inc[AW-1:0];
                                end
                            end
                            lmfs_pkg::REQ_ROLL_RIGHT:
                            begin
                                if (off_reg == '0)
                                begin
                                    off_reg <= AW'(NUM_COLUMNS - 1);
                                end
                                else
                                begin
                                    off_reg <= off_reg - AW'(1);
                                end
                            end
                            lmfs_pkg::REQ_ROLL_DOWN:
                            begin
                                rot_reg <= rot_reg + lmfs_pkg::ROW_W'(1);
                            end
                            lmfs_pkg::REQ_REFRESH:
                            begin
                                rd_cnt_reg <= '0;
                                state_reg  <= ST_SNAP;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SP_WRITE:
                begin
                    valid_reg[sp_addr_reg] <= 1'b1;
                    state_reg              <= ST_IDLE;
                end
                ST_SNAP:
                begin
                    rd_cnt_reg <= rd_cnt_reg + RD_W'(1);
                    if (rd_cnt_reg == RD_W'(lmfs_pkg::DISP_COLS - 1))
                    begin
                        state_reg <= ST_TAIL;
                    end
                end
                ST_TAIL:
                begin
                    out_cnt_reg <= '0;
                    state_reg   <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        out_cnt_reg <= out_cnt_reg + CNT_W'(1);
                        if (out_cnt_reg == CNT_W'(NUM_WR - 1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            sp_addr_reg <= phys;
            sp_mask_reg <= DW'(1) << (req.row - rot_reg);
        end
        pend_addr_reg <= phys;
        pend_idx_reg  <= rd_cnt_reg;
        pend_in_reg   <= in_range;
        if (cap_valid_reg)
        begin
            for (int r = 0; r < lmfs_pkg::ROWS; r++)
            begin
                rows_reg[r][pend_idx_reg] <= cap_byte[r];
            end
        end
        if (out_load)
        begin
            out_addr_reg <= lmfs_pkg::ADDR_W'(emit_row) + lmfs_pkg::ADDR_W'(1);
            out_data_reg <= lmfs_pkg::bitrev8(emit_word[emit_seg*lmfs_pkg::SEG_COLS +: DW]);
            out_fe_reg   <= (emit_seg == SEG_W'(lmfs_pkg::NUM_SEGS - 1));
            out_last_reg <= (out_cnt_reg == CNT_W'(NUM_WR - 1));
        end
    end

    assign wr.valid       = out_valid_reg;
    assign wr.reg_address = out_addr_reg;
    assign wr.reg_data    = out_data_reg;
    assign wr.frame_end   = out_fe_reg;
    assign wr.last        = out_last_reg;

    // checks
    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        wr.valid && wr.last |-> wr.frame_end)
        else $error("last write not on a frame end");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr.valid |-> (wr.reg_address != '0) && (wr.reg_address <= 4'd8))
        else $error("row register address out of range");

    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        wr.valid && wr.ready && !wr.last |=> wr.valid)
        else $error("gap inside a refresh run");

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        IW'(off_reg) < IW'(NUM_COLUMNS))
        else $error("column offset beyond the store");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for led_matrix_frame_scroller_core. Requests go in over
// valid/ready. A column buffer in the bench follows each accepted request.
// Every refresh queues the 32 register writes it should cause. Each write
// leaving the block is checked field by field against the oldest entry. A
// directed table runs first, then random requests under three idling mixes.
// ----------------------------------------------------------------------------
module tb;

    import lmfs_pkg::*;

    // request codes the block has to ignore
    localparam logic [TYPE_W-1:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [TYPE_W-1:0] REQ_UNUSED_7 = 3'd7;

    localparam int RANDOM_ITEMS = 380;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [TYPE_W-1:0] typ;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  pix_row;
        logic              typed;      // reg_data of every write given below
        logic [DATA_W-1:0] fill;
    } req_step_t;

    typedef struct packed {
        logic [ADDR_W-1:0] reg_address;
        logic [DATA_W-1:0] reg_data;
        logic              frame_end;
        logic              last;
    } disp_write_t;

    logic clk;
    logic rst_n;

    lmfs_req_if req_if ();
    lmfs_wr_if  wr_if ();

    led_matrix_frame_scroller_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .wr    (wr_if)
    );

    logic [DATA_W-1:0] lit_cols [NUM_COLUMNS_DEF];
    disp_write_t       pending_writes [$];
    int unsigned       src_idle_pct;
    int unsigned       snk_idle_pct;
    bit                any_error;

    req_step_t directed_steps [22] = '{
        '{REQ_REFRESH,    5'd0,  3'd0, 1'b1, 8'h00},  // empty after reset
        '{REQ_SET,        5'd0,  3'd0, 1'b0, 8'h00},
        '{REQ_SET,        5'd31, 3'd7, 1'b0, 8'h00},
        '{REQ_SET,        5'd7,  3'd3, 1'b0, 8'h00},
        '{REQ_SET,        5'd24, 3'd0, 1'b0, 8'h00},
        '{REQ_REFRESH,    5'd0,  3'd0, 1'b0, 8'h00},
        '{REQ_ROLL_LEFT,  5'd0,  3'd0, 1'b0, 8'h00},
        '{REQ_REFRESH,    5'd0,  3'd0, 1'b0, 8'h00},
        '{REQ_ROLL_RIGHT, 5'd0,  3'd0, 1'b0, 8'h00},
        '{REQ_ROLL_RIGHT, 5'd0,  3'd0, 1'b0, 8'h00},
        '{REQ_REFRESH,    5'd0,  3'd0, 1'b0, 8'h00},
        '{REQ_ROLL_DOWN,  5'd0,  3'd0, 1'b0, 8'h00},
        '{REQ_REFRESH,    5'd0,  3'd0, 1'b0, 8'h00},
        '{REQ_UNUSED_6,   5'd0,  3'd0, 1'b0, 8'h00},
        '{REQ_UNUSED_7,   5'd31, 3'd7, 1'b0, 8'h00},
        '{REQ_REFRESH,    5'd0,  3'd0, 1'b0, 8'h00},
        '{REQ_CLEAR,      5'd0,  3'd0, 1'b0, 8'h00},
        '{REQ_REFRESH,    5'd0,  3'd0, 1'b1, 8'h00},  // empty after clear
        '{REQ_SET,        5'd16, 3'd5, 1'b0, 8'h00},
        '{REQ_ROLL_DOWN,  5'd0,  3'd0, 1'b0, 8'h00},
        '{REQ_ROLL_LEFT,  5'd0,  3'd0, 1'b0, 8'h00},
        '{REQ_REFRESH,    5'd0,  3'd0, 1'b0, 8'h00}
    };

    always #5 clk = ~clk;

    // Follows one request on the bench's buffer; a refresh queues its writes.
    function automatic void track_request(input logic [TYPE_W-1:0] typ,
                                          input logic [COL_W-1:0]  col,
                                          input logic [ROW_W-1:0]  pix_row,
                                          input logic              typed,
                                          input logic [DATA_W-1:0] fill);
        logic [DATA_W-1:0] edge_col;
        disp_write_t       wr_exp;
        int                r;
        int                s;
        int                i;

        case (typ)
            REQ_CLEAR:
            begin
                for (i = 0; i < NUM_COLUMNS_DEF; i++)
                begin
                    lit_cols[i] = '0;
                end
            end
            REQ_SET:
            begin
                if (col < NUM_COLUMNS_DEF)
                begin
                    lit_cols[col][pix_row] = 1'b1;
                end
            end
            REQ_ROLL_LEFT:
            begin
                edge_col = lit_cols[0];
                for (i = 0; i < NUM_COLUMNS_DEF - 1; i++)
                begin
                    lit_cols[i] = lit_cols[i+1];
                end
                lit_cols[NUM_COLUMNS_DEF-1] = edge_col;
            end
            REQ_ROLL_RIGHT:
            begin
                edge_col = lit_cols[NUM_COLUMNS_DEF-1];
                for (i = NUM_COLUMNS_DEF - 1; i > 0; i--)
                begin
                    lit_cols[i] = lit_cols[i-1];
                end
                lit_cols[0] = edge_col;
            end
            REQ_ROLL_DOWN:
            begin
                for (i = 0; i < NUM_COLUMNS_DEF; i++)
                begin
                    lit_cols[i] = {lit_cols[i][DATA_W-2:0], lit_cols[i][DATA_W-1]};
                end
            end
            REQ_REFRESH:
            begin
                for (r = 0; r < ROWS; r++)
                begin
                    for (s = 0; s < NUM_SEGS; s++)
                    begin
                        wr_exp.reg_address = ADDR_W'(r + 1);
                        wr_exp.frame_end   = (s == NUM_SEGS - 1);
                        wr_exp.last        = (r == ROWS - 1) && (s == NUM_SEGS - 1);
                        // segment's first column lands in bit 7
                        for (i = 0; i < SEG_COLS; i++)
                        begin
                            wr_exp.reg_data[SEG_COLS-1-i] =
                                (s * SEG_COLS + i < NUM_COLUMNS_DEF) ?
                                lit_cols[s*SEG_COLS+i][r] : 1'b0;
                        end
                        if (typed)
                        begin
                            wr_exp.reg_data = fill;
                        end
                        pending_writes.push_back(wr_exp);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_request(input logic [TYPE_W-1:0] typ,
                                input logic [COL_W-1:0]  col,
                                input logic [ROW_W-1:0]  pix_row,
                                input logic              typed,
                                input logic [DATA_W-1:0] fill);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= typ;
        req_if.column   <= col;
        req_if.row      <= pix_row;
        do
        begin
            @(posedge clk);
        end
        while (req_if.ready !== 1'b1);
        track_request(typ, col, pix_row, typed, fill);
    endtask

    task automatic wait_writes_drained();
        while (pending_writes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // write side: random back-pressure, check each accepted item
    initial
    begin
        disp_write_t wr_exp;

        forever
        begin
            wr_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            @(posedge clk);
            if (wr_if.valid === 1'b1 && wr_if.ready === 1'b1)
            begin
                if (pending_writes.size() == 0)
                begin
                    $error("unexpected write: addr %0d data %02h",
                           wr_if.reg_address, wr_if.reg_data);
                    any_error = 1'b1;
                end
                else
                begin
                    wr_exp = pending_writes.pop_front();
                    if (wr_if.reg_address !== wr_exp.reg_address)
                    begin
                        $error("reg_address: expected %0d, got %0d",
                               wr_exp.reg_address, wr_if.reg_address);
                        any_error = 1'b1;
                    end
                    if (wr_if.reg_data !== wr_exp.reg_data)
                    begin
                        $error("reg_data: expected %02h, got %02h",
                               wr_exp.reg_data, wr_if.reg_data);
                        any_error = 1'b1;
                    end
                    if (wr_if.frame_end !== wr_exp.frame_end)
                    begin
                        $error("frame_end: expected %0b, got %0b",
                               wr_exp.frame_end, wr_if.frame_end);
                        any_error = 1'b1;
                    end
                    if (wr_if.last !== wr_exp.last)
                    begin
                        $error("last: expected %0b, got %0b",
                               wr_exp.last, wr_if.last);
                        any_error = 1'b1;
                    end
                end
            end
        end
    end

    initial
    begin
        int                issued;
        int unsigned       pick;
        logic [TYPE_W-1:0] typ;
        int                i;

        clk             = 1'b0;
        rst_n           = 1'b0;
        any_error       = 1'b0;
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_CLEAR;
        req_if.column   = '0;
        req_if.row      = '0;
        src_idle_pct    = 34;
        snk_idle_pct    = 85;
        for (i = 0; i < NUM_COLUMNS_DEF; i++)
        begin
            lit_cols[i] = '0;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[k])
        begin
            send_request(directed_steps[k].typ, directed_steps[k].col,
                         directed_steps[k].pix_row, directed_steps[k].typed,
                         directed_steps[k].fill);
        end

        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            if (issued == RANDOM_ITEMS / 3 || issued == 2 * RANDOM_ITEMS / 3)
            begin
                // hold off until the write side has caught up
                req_if.valid <= 1'b0;
                @(posedge clk);
                wait_writes_drained();
                src_idle_pct = (issued == RANDOM_ITEMS / 3) ? 85 : 0;
                snk_idle_pct = (issued == RANDOM_ITEMS / 3) ? 34 : 0;
            end
            pick = $urandom_range(99);
            if (pick < 3)
                typ = REQ_CLEAR;
            else if (pick < 50)
                typ = REQ_SET;
            else if (pick < 60)
                typ = REQ_ROLL_LEFT;
            else if (pick < 70)
                typ = REQ_ROLL_RIGHT;
            else if (pick < 78)
                typ = REQ_ROLL_DOWN;
            else if (pick < 95)
                typ = REQ_REFRESH;
            else
                typ = pick[0] ? REQ_UNUSED_7 : REQ_UNUSED_6;
            send_request(typ, COL_W'($urandom_range(31)), ROW_W'($urandom_range(7)),
                         1'b0, 8'h00);
            if (typ != REQ_UNUSED_6 && typ != REQ_UNUSED_7)
            begin
                issued++;
            end
        end
        req_if.valid <= 1'b0;

        wait_writes_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (any_error || pending_writes.size() != 0)
        begin
            $display("tb failed");
        end
        else
        begin
            $display("tb passed");
        end
        $finish;
    end

    // hang guard: far beyond the slowest correct run
    initial
    begin
        #10_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
